// ===== hdl/fba_pkg.sv =====
package fba_pkg;

  localparam int POOL_BLOCKS = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int USED_W      = 12;
  localparam int CTR_W       = 32;
  localparam int STRIDE_W    = 16;
  localparam int OFF_W       = 22;
  localparam int REM_W       = STRIDE_W + IDX_W;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_NOT_OWNED  = 3'd2,
    ST_NOT_ACTIVE = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  localparam logic [2:0] CFG_BLOCK_SIZE  = 3'd0;
  localparam logic [2:0] CFG_ALIGN_LOG2  = 3'd1;
  localparam logic [2:0] CFG_SLAB_BLOCKS = 3'd2;
  localparam logic [2:0] CFG_MAX_BLOCKS  = 3'd3;
  localparam logic [2:0] CFG_TRACKING    = 3'd4;

  typedef struct packed {
    op_t         op;
    logic [31:0] handle_offset;
    logic        is_null;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OFF_W-1:0] block_offset;
    logic [CNT_W-1:0] in_use_cnt;
    logic [CNT_W-1:0] stack_cnt;
    logic [CNT_W-1:0] grown_cnt;
    logic [CNT_W-1:0] peak_used;
    logic [CNT_W-1:0] slab_cnt;
    logic [CTR_W-1:0] alloc_count;
    logic [CTR_W-1:0] free_count;
    logic [CTR_W-1:0] failed_count;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic             is_null;
    logic             owned_ok;
    logic [IDX_W-1:0] q;
  } work_t;

  function automatic logic [STRIDE_W-1:0] fba_stride(input logic [12:0] bs,
                                                     input logic [3:0] al_log2);
    logic [STRIDE_W-1:0] b;
    logic [STRIDE_W-1:0] a;
    logic [STRIDE_W-1:0] m;
    b = (bs < 13'd8) ? STRIDE_W'(8) : STRIDE_W'(bs);
    a = STRIDE_W'(1) << al_log2;
    if (a < STRIDE_W'(8)) a = STRIDE_W'(8);
    m = a - STRIDE_W'(1);
    return (b + m) & ~m;
  endfunction

endpackage

// ===== hdl/fba_front.sv =====
module fba_front import fba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  input  logic [STRIDE_W-1:0] stride,
  output logic                push_valid,
  input  logic                push_ready,
  output work_t               push_item
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t          state;
  op_t              op;
  logic             is_null;
  logic             owned_ok;
  logic [IDX_W-1:0] q;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dvs;
  logic [3:0]       div_step;

  logic             in_range;
  logic             needs_div;
  logic             ge;
  logic [REM_W-1:0] rem_sub;

  assign in_range  = in_data.handle_offset < {{(32-REM_W){1'b0}}, stride, {IDX_W{1'b0}}};
  assign needs_div = (in_data.op == OP_FREE || in_data.op == OP_QUERY) && !in_data.is_null
                     && in_range;
  assign ge        = rem >= dvs;
  assign rem_sub   = ge ? rem - dvs : rem;

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_item  = '{op: op, is_null: is_null, owned_ok: owned_ok, q: q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            op       <= in_data.op;
            is_null  <= in_data.is_null;
            owned_ok <= 1'b0;
            q        <= '0;
            rem      <= in_data.handle_offset[REM_W-1:0];
            dvs      <= {1'b0, stride, {(IDX_W-1){1'b0}}};
            div_step <= 4'(IDX_W - 1);
            state    <= needs_div ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          rem <= rem_sub;
          q   <= {q[IDX_W-2:0], ge};
          dvs <= dvs >> 1;
          if (div_step == 4'd0) begin
            owned_ok <= (rem_sub == '0);
            state    <= F_PUSH;
          end else begin
            div_step <= div_step - 4'd1;
          end
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/fba_queue.sv =====
module fba_queue import fba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_item
);

  work_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== hdl/fba_back.sv =====
module fba_back import fba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  work_t               pop_item,
  output logic [STRIDE_W-1:0] stride,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_POP   = 6'b000100,
    S_CHK   = 6'b001000,
    S_SWEEP = 6'b010000,
    S_DONE  = 6'b100000
  } bstate_t;

  bstate_t state;

  logic [12:0]      blk_bytes;
  logic [3:0]       align_log2;
  logic [CNT_W-1:0] slab_len;
  logic [CNT_W-1:0] blk_cap;
  logic             tracking;

  logic [CNT_W-1:0]  depth;
  logic [CNT_W-1:0]  virt_top;
  logic [IDX_W-1:0]  slab_base;
  logic [CNT_W-1:0]  grown;
  logic [USED_W-1:0] used;
  logic [USED_W-1:0] peak;
  logic [CNT_W-1:0]  slabs;
  logic [CTR_W-1:0]  alloc_total;
  logic [CTR_W-1:0]  free_total;
  logic [CTR_W-1:0]  fail_total;

  work_t            cur;
  status_t          res_status;
  logic [OFF_W-1:0] res_off;
  logic             virt;
  logic [IDX_W-1:0] vval;
  logic [CNT_W-1:0] sweep_cnt;
  logic             sweep_reply;

  logic [IDX_W-1:0] stack_mem [POOL_BLOCKS];
  logic             active_mem [POOL_BLOCKS];
  logic [IDX_W-1:0] stack_rd;
  logic             act_rd;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  room;
  logic              can_grow;
  logic [CNT_W-1:0]  grow_n;
  logic [CNT_W-1:0]  dm1;
  logic              owned;
  logic              chk_ok;
  logic [IDX_W-1:0]  pop_idx;
  logic [REM_W-1:0]  prod;
  logic [USED_W-1:0] used_inc;
  logic              clear_now;
  logic              act_we;
  logic [IDX_W-1:0]  act_waddr;
  logic              act_wdata;
  logic [CNT_W-1:0]  sweep_m1;

  assign stride    = fba_stride(blk_bytes, align_log2);
  assign lim       = (blk_cap == '0 || blk_cap > CNT_W'(POOL_BLOCKS))
                     ? CNT_W'(POOL_BLOCKS) : blk_cap;
  assign room      = lim - grown;
  assign can_grow  = (grown < lim) && (slab_len != '0);
  assign grow_n    = (slab_len > room) ? room : slab_len;
  assign dm1       = depth - CNT_W'(1);
  assign owned     = cur.owned_ok && ({1'b0, cur.q} < grown);
  assign chk_ok    = !(tracking && !act_rd) && (depth < CNT_W'(POOL_BLOCKS));
  assign pop_idx   = virt ? vval : stack_rd;
  assign prod      = REM_W'(pop_idx) * REM_W'(stride);
  assign used_inc  = used + USED_W'(1);
  assign sweep_m1  = sweep_cnt - CNT_W'(1);
  assign clear_now = (state == S_IDLE && cfg_valid && cfg_index <= CFG_TRACKING)
                     || (state == S_EXEC && cur.op == OP_CLEAR);

  assign cfg_ready = (state == S_IDLE);
  assign pop_ready = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    act_we    = 1'b0;
    act_waddr = cur.q;
    act_wdata = 1'b0;
    if (state == S_POP) begin
      act_we    = tracking;
      act_waddr = pop_idx;
      act_wdata = 1'b1;
    end else if (state == S_CHK) begin
      act_we = chk_ok && tracking;
    end else if (state == S_SWEEP) begin
      act_we    = (sweep_cnt != '0);
      act_waddr = sweep_m1[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHK && chk_ok) stack_mem[depth[IDX_W-1:0]] <= cur.q;
    stack_rd <= stack_mem[dm1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (act_we) active_mem[act_waddr] <= act_wdata;
    act_rd <= active_mem[cur.q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_cnt   <= CNT_W'(POOL_BLOCKS);
      sweep_reply <= 1'b0;
      blk_bytes   <= 13'd64;
      align_log2  <= 4'd3;
      slab_len    <= CNT_W'(64);
      blk_cap     <= '0;
      tracking    <= 1'b1;
      depth       <= '0;
      virt_top    <= '0;
      grown       <= '0;
      used        <= '0;
      peak        <= '0;
      slabs       <= '0;
      alloc_total <= '0;
      free_total  <= '0;
      fail_total  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              CFG_BLOCK_SIZE:  blk_bytes  <= cfg_data;
              CFG_ALIGN_LOG2:  align_log2 <= cfg_data[3:0];
              CFG_SLAB_BLOCKS: slab_len   <= cfg_data[CNT_W-1:0];
              CFG_MAX_BLOCKS:  blk_cap    <= cfg_data[CNT_W-1:0];
              CFG_TRACKING:    tracking   <= cfg_data[0];
              default: ;
            endcase
            if (cfg_index <= CFG_TRACKING) begin
              sweep_cnt   <= grown;
              sweep_reply <= 1'b0;
              state       <= S_SWEEP;
            end
          end else if (pop_valid) begin
            cur        <= pop_item;
            res_status <= ST_OK;
            res_off    <= '0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cur.op)
            OP_ALLOC: begin
              if (depth == '0) begin
                if (can_grow) begin
                  grown     <= grown + grow_n;
                  slabs     <= slabs + CNT_W'(1);
                  slab_base <= grown[IDX_W-1:0];
                  virt_top  <= grow_n;
                  depth     <= grow_n;
                end else begin
                  res_status <= ST_EXHAUSTED;
                  if (fail_total != '1) fail_total <= fail_total + CTR_W'(1);
                  state <= S_DONE;
                end
              end else begin
                depth <= dm1;
                virt  <= dm1 < virt_top;
                vval  <= slab_base + dm1[IDX_W-1:0];
                state <= S_POP;
              end
            end
            OP_FREE: begin
              if (cur.is_null) begin
                state <= S_DONE;
              end else if (!owned) begin
                res_status <= ST_NOT_OWNED;
                state      <= S_DONE;
              end else begin
                state <= S_CHK;
              end
            end
            OP_CLEAR: begin
              sweep_cnt   <= grown;
              sweep_reply <= 1'b1;
              state       <= S_SWEEP;
            end
            OP_QUERY: begin
              if (cur.is_null || !owned) res_status <= ST_NOT_OWNED;
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_POP: begin
          res_off <= prod[OFF_W-1:0];
          if (alloc_total != '1) alloc_total <= alloc_total + CTR_W'(1);
          used <= used_inc;
          if (used_inc > peak) peak <= used_inc;
          state <= S_DONE;
        end
        S_CHK: begin
          if (tracking && !act_rd) begin
            res_status <= ST_NOT_ACTIVE;
          end else if (!chk_ok) begin
            res_status <= ST_OVERFLOW;
          end else begin
            depth <= depth + CNT_W'(1);
            if (depth < virt_top) virt_top <= depth;
            if (used != '0) used <= used - USED_W'(1);
            if (free_total != '1) free_total <= free_total + CTR_W'(1);
          end
          state <= S_DONE;
        end
        S_SWEEP: begin
          if (sweep_cnt == '0) begin
            state <= sweep_reply ? S_DONE : S_IDLE;
          end else begin
            sweep_cnt <= sweep_m1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= '{status:       res_status,
                           block_offset: res_off,
                           in_use_cnt:   used[CNT_W-1:0],
                           stack_cnt:    depth,
                           grown_cnt:    grown,
                           peak_used:    peak[CNT_W-1:0],
                           slab_cnt:     slabs,
                           alloc_count:  alloc_total,
                           free_count:   free_total,
                           failed_count: fail_total};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (clear_now) begin
        depth    <= '0;
        virt_top <= '0;
        grown    <= '0;
        used     <= '0;
        peak     <= '0;
        slabs    <= '0;
      end
    end
  end

endmodule

// ===== hdl/fixed_block_allocator.sv =====
// result timing depends on the op: free and query first pass through the front-end
// stride divider, allocate reads the free stack and may first grow a slab, and other ops
// need no division or stack access
// the front takes a new transaction only once the last one is pushed to the queue, and a
// clear or config write holds off the back while the grown entries of the active bitmap are swept
// reset: synchronous, clears statistics and config to defaults, then sweeps the
// 1024-entry active bitmap before the first transaction is served
module fixed_block_allocator import fba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [STRIDE_W-1:0] stride;
  logic                push_valid;
  logic                push_ready;
  work_t               push_item;
  logic                pop_valid;
  logic                pop_ready;
  work_t               pop_item;

  fba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .stride     (stride),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  fba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  fba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .stride    (stride),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_OVERFLOW)
    else $error("status code out of range");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> out_data.block_offset == '0)
    else $error("offset returned on failed transaction");

  a_pool_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.grown_cnt <= CNT_W'(POOL_BLOCKS)
                   && out_data.stack_cnt <= CNT_W'(POOL_BLOCKS)))
    else $error("pool counts beyond capacity");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |-> !(cfg_valid && cfg_ready))
    else $error("queue pop collides with config write");

endmodule

// ===== sim/fixed_block_allocator_tb.sv =====
module fixed_block_allocator_tb;
  import fba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class alloc_scoreboard;
    logic [12:0] blk_size;
    logic [3:0]  al_log2;
    logic [10:0] slab_blocks;
    logic [10:0] max_blk;
    bit          track;
    logic [9:0]  free_list [POOL_BLOCKS];
    bit          active [POOL_BLOCKS];
    int unsigned depth, grown, used, peak, slabs;
    logic [31:0] allocs, frees, fails;
    out_item_t   pending [$];
    int          mismatches;

    function void clear_pool();
      foreach (active[i]) active[i] = 0;
      depth = 0; grown = 0; used = 0; peak = 0; slabs = 0;
    endfunction

    function void reset_all();
      blk_size = 64; al_log2 = 3; slab_blocks = 64; max_blk = 0; track = 1;
      clear_pool();
      allocs = 0; frees = 0; fails = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [12:0] val);
      case (idx)
        CFG_BLOCK_SIZE:  blk_size = val;
        CFG_ALIGN_LOG2:  al_log2 = val[3:0];
        CFG_SLAB_BLOCKS: slab_blocks = val[10:0];
        CFG_MAX_BLOCKS:  max_blk = val[10:0];
        CFG_TRACKING:    track = val[0];
        default: return;
      endcase
      clear_pool();
    endfunction

    function longint unsigned stride();
      longint unsigned b, a;
      b = (blk_size < 8) ? 8 : blk_size;
      a = 64'd1 << al_log2;
      if (a < 8) a = 8;
      return (b + a - 1) & ~(a - 1);
    endfunction

    function int unsigned limit();
      return (max_blk == 0 || max_blk > POOL_BLOCKS) ? POOL_BLOCKS : max_blk;
    endfunction

    function bit grow();
      int unsigned n, lim;
      lim = limit();
      n = slab_blocks;
      if (grown >= lim || n == 0) return 0;
      if (n > lim - grown) n = lim - grown;
      for (int unsigned i = 0; i < n && depth < POOL_BLOCKS; i++) begin
        free_list[depth] = 10'(grown + i);
        depth++;
      end
      grown += n;
      slabs++;
      return 1;
    endfunction

    function bit owned(longint unsigned off, output int unsigned idx);
      longint unsigned st;
      st = stride();
      idx = 0;
      if (off >= grown * st || off % st != 0) return 0;
      idx = 32'(off / st);
      return idx < POOL_BLOCKS;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int unsigned idx;
      status_t s;
      longint unsigned off;
      s = ST_OK;
      off = 0;
      case (it.op)
        OP_ALLOC: begin
          if (depth == 0 && !grow()) begin
            s = ST_EXHAUSTED;
            if (fails != '1) fails++;
          end else begin
            depth--;
            idx = free_list[depth];
            if (track) active[idx] = 1;
            off = idx * stride();
            if (allocs != '1) allocs++;
            used++;
            if (used > peak) peak = used;
          end
        end
        OP_FREE: if (!it.is_null) begin
          if (!owned(it.handle_offset, idx)) s = ST_NOT_OWNED;
          else if (track && !active[idx]) s = ST_NOT_ACTIVE;
          else if (depth >= POOL_BLOCKS) s = ST_OVERFLOW;
          else begin
            if (track) active[idx] = 0;
            free_list[depth] = 10'(idx);
            depth++;
            if (used > 0) used--;
            if (frees != '1) frees++;
          end
        end
        OP_CLEAR: clear_pool();
        default: if (it.is_null || !owned(it.handle_offset, idx)) s = ST_NOT_OWNED;
      endcase
      r.status = s;
      r.block_offset = off[OFF_W-1:0];
      r.in_use_cnt = used[CNT_W-1:0];
      r.stack_cnt = depth[CNT_W-1:0];
      r.grown_cnt = grown[CNT_W-1:0];
      r.peak_used = peak[CNT_W-1:0];
      r.slab_cnt = slabs[CNT_W-1:0];
      r.alloc_count = allocs;
      r.free_count = frees;
      r.failed_count = fails;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [2:0] cfg_index;
  logic [12:0] cfg_data;

  alloc_scoreboard sb;
  int idle_cycles;
  bit long_hold;

  // handles of blocks handed out, to build well-formed frees
  logic [31:0] live_offsets [$];

  fixed_block_allocator DUT (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.reset_all();
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (rst || in_valid && in_ready || out_valid && out_ready || cfg_valid && cfg_ready)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("fixed_block_allocator_tb: done, errors");
        $finish;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int w;
    out_ready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(op_t op, logic [31:0] off, logic nul, int gap);
    in_item_t it;
    it.op = op; it.handle_offset = off; it.is_null = nul;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    if (op == OP_ALLOC && sb.pending[$].status == ST_OK)
      live_offsets.insert(live_offsets.size(), 32'(sb.pending[$].block_offset));
    if (op == OP_CLEAR) live_offsets.delete();
    if (op == OP_FREE && !nul && sb.pending[$].status == ST_OK)
      foreach (live_offsets[i])
        if (live_offsets[i] == off) begin
          live_offsets.delete(i);
          break;
        end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [12:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.write_reg(idx, val);
    live_offsets.delete();
    @(posedge clk);
  endtask

  task automatic set_all(logic [12:0] bs, logic [12:0] al, logic [12:0] bps,
                         logic [12:0] mx, logic [12:0] tr);
    write_cfg(CFG_BLOCK_SIZE, bs);
    write_cfg(CFG_ALIGN_LOG2, al);
    write_cfg(CFG_SLAB_BLOCKS, bps);
    write_cfg(CFG_MAX_BLOCKS, mx);
    write_cfg(CFG_TRACKING, tr);
  endtask

  function automatic int gap_draw();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic random_item(int gap);
    int k;
    logic [31:0] off;
    longint unsigned st;
    k = $urandom_range(0, 99);
    st = sb.stride();
    if (k < 40) send(OP_ALLOC, $urandom, 1'($urandom_range(0, 1)), gap);
    else if (k < 70 && live_offsets.size() > 0) begin
      off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
      send(OP_FREE, off, 0, gap);
    end else if (k < 78) begin
      off = 32'($urandom_range(0, sb.grown + 1) * st);
      send(OP_FREE, off, $urandom_range(0, 7) == 0, gap);
    end else if (k < 82) send(OP_FREE, $urandom, 1'($urandom_range(0, 1)), gap);
    else if (k < 95) begin
      off = (k < 92) ? 32'($urandom_range(0, sb.grown + 1) * st) : $urandom;
      send(OP_QUERY, off, $urandom_range(0, 7) == 0, gap);
    end else if (k < 97) send(OP_CLEAR, $urandom, 1'($urandom_range(0, 1)), gap);
    else send(OP_FREE, 32'($urandom_range(0, sb.grown) * st + $urandom_range(1, 7)), 0, gap);
  endtask

  initial begin
    rst <= 1;
    in_valid <= 0;
    in_data <= '0;
    cfg_valid <= 0;
    cfg_index <= CFG_BLOCK_SIZE;
    cfg_data <= '0;
    long_hold = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default config
    send(OP_ALLOC, 32'hFFFF_FFFF, 1, 0);
    send(OP_ALLOC, 0, 0, 0);
    send(OP_QUERY, 32'd0, 0, 0);
    send(OP_QUERY, 32'd64 * 63, 0, 0);
    send(OP_QUERY, 32'd64 * 64, 0, 0);
    send(OP_QUERY, 32'd3, 0, 0);
    send(OP_QUERY, 32'd0, 1, 0);
    send(OP_FREE, 32'd64 * 63, 0, 0);
    send(OP_FREE, 32'd64 * 63, 0, 0);
    send(OP_FREE, 32'hFFFF_FFFF, 0, 0);
    send(OP_FREE, 32'd0, 1, 0);
    send(OP_FREE, 32'd65, 0, 0);
    send(OP_CLEAR, 32'hAAAA_5555, 0, 0);
    send(OP_FREE, 32'd0, 0, 0);
    drain();

    // tiny pool: exhaustion, tracking off double free
    set_all(13'd1, 13'd0, 13'd1, 13'd2, 13'd0);
    send(OP_ALLOC, 0, 0, 0);
    send(OP_ALLOC, 0, 0, 0);
    send(OP_ALLOC, 0, 0, 0);
    send(OP_FREE, 32'd8, 0, 0);
    send(OP_FREE, 32'd8, 0, 0);
    send(OP_FREE, 32'd8, 0, 0);
    drain();
    // slab of zero blocks never grows
    write_cfg(CFG_SLAB_BLOCKS, 13'd0);
    send(OP_ALLOC, 0, 0, 0);
    drain();
    // full stack with tracking off: overflow
    set_all(13'd8, 13'd3, 13'd1024, 13'd0, 13'd0);
    send(OP_ALLOC, 0, 0, 0);
    send(OP_FREE, 32'd8 * 1023, 0, 0);
    send(OP_FREE, 32'd8 * 1022, 0, 0);
    drain();
    // largest stride and out-of-range field values
    set_all(13'd8191, 13'd15, 13'd2047, 13'd2047, 13'd1);
    send(OP_ALLOC, 0, 0, 0);
    send(OP_ALLOC, 0, 0, 0);
    send(OP_QUERY, 32'h0001_0000, 0, 0);
    drain();

    // random phases with different settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_all(13'd64, 13'd3, 13'd64, 13'd0, 13'd1);
        1: set_all(13'd4096, 13'd12, 13'd4, 13'd16, 13'd1);
        2: set_all(13'd1, 13'd0, 13'd1, 13'd1, 13'd1);
        3: set_all(13'd24, 13'd4, 13'd7, 13'd30, 13'd0);
        4: set_all(13'($urandom_range(1, 8191)), 13'($urandom_range(0, 15)),
                   13'($urandom_range(1, 40)), 13'($urandom_range(0, 60)),
                   13'($urandom_range(0, 1)));
        5: set_all(13'd100, 13'd5, 13'd1024, 13'd1024, 13'd1);
        6: set_all(13'($urandom), 13'($urandom), 13'($urandom_range(0, 10)),
                   13'($urandom_range(0, 20)), 13'($urandom));
        default: set_all(13'd12, 13'd2, 13'd3, 13'd0, 13'd1);
      endcase
      if (ph == 1) long_hold = 1;
      for (int n = 0; n < 125; n++)
        random_item((ph == 1 || $urandom_range(0, 4) == 0) ? 0 : gap_draw());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("fixed_block_allocator_tb: done, clean");
    else
      $display("fixed_block_allocator_tb: done, errors");
    $finish;
  end

endmodule
